// ===== rtl/tkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tkv_pkg
// Shared widths, defaults and codes of the timestamped key/value table.
// ----------------------------------------------------------------------------
package tkv_pkg;

    // default sizes for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 64;

    // fixed field widths
    localparam int OP_BITS     = 2;
    localparam int KEY_BITS    = 32;
    localparam int TIME_BITS   = 32;
    localparam int WORD_BITS   = 64;
    localparam int RAND_BITS   = 32;
    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = 4;
    localparam int USED_BITS   = 5;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_BITS = 160;
    localparam int M_TDATA_BITS = 144;

    // operation codes
    typedef enum logic [OP_BITS-1:0] {
        OP_MERGE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_PICK   = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STS_INSERTED  = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_STALE     = 3'd2,
        STS_FULL      = 3'd3,
        STS_FOUND     = 3'd4,
        STS_NOT_FOUND = 3'd5,
        STS_PICKED    = 3'd6,
        STS_EMPTY     = 3'd7
    } status_t;

endpackage

// ===== rtl/timestamped_key_value_table.sv =====
// ----------------------------------------------------------------------------
// timestamped_key_value_table
// Last-writer-wins key/value table: merge, lookup and random pick over a
// table that fills in order from slot zero.
//
//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+---------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | one operation word
//  m_      | out | m_tvalid m_tready m_tdata m_tuser | one result word per op
//
// Merge and lookup scan the entry memory one slot per cycle through its
// registered read port, comparing each slot's data as the next slot is read.
// Pick runs the bit-serial remainder unit, then reads the picked slot.
// One operation at a time: s_tready is low from acceptance until the result
// word is taken; operation code 3 is taken and dropped with no result.
// Reset clears the entry count, sequencer state and compare flag only; no clearing pass over the memory.
// ----------------------------------------------------------------------------
module timestamped_key_value_table #(
    parameter int TABLE_DEPTH = tkv_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = tkv_pkg::VALUE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_id[31:0], timestamp[63:32], value_word[127:64], random_word[159:128]
    input  logic [tkv_pkg::S_TDATA_BITS-1:0] s_tdata,
    // operation[1:0]
    input  logic [tkv_pkg::OP_BITS-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot[3:0], entry_key[35:4], entry_time[67:36], entry_value[131:68],
    // entries_used[136:132], zero fill above
    output logic [tkv_pkg::M_TDATA_BITS-1:0] m_tdata,
    // status[2:0]
    output logic [tkv_pkg::STATUS_BITS-1:0]  m_tuser
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(TABLE_DEPTH);

    localparam int KB = tkv_pkg::KEY_BITS;
    localparam int TB = tkv_pkg::TIME_BITS;
    localparam int WB = tkv_pkg::WORD_BITS;
    localparam int RB = tkv_pkg::RAND_BITS;
    localparam int SB = tkv_pkg::SLOT_BITS;
    localparam int UB = tkv_pkg::USED_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MODW  = 5'b00100,
        S_PDATA = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tkv_pkg::OP_BITS-1:0] op_reg, op_next;
    logic [KB-1:0]               key_reg, key_next;
    logic [TB-1:0]               time_reg, time_next;
    logic [VALUE_BITS-1:0]       val_reg, val_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [FILL_W-1:0]           scan_reg, scan_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;

    tkv_pkg::status_t            sts_reg, sts_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [KB-1:0]               okey_reg, okey_next;
    logic [TB-1:0]               otime_reg, otime_next;
    logic [VALUE_BITS-1:0]       oval_reg, oval_next;

    // memory and remainder unit hookup
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [KB-1:0]         rd_key;
    logic [TB-1:0]         rd_time;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  mod_start;
    logic                  mod_done;
    logic [FILL_W-1:0]     mod_rem;
    logic                  hit;

    tkv_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (key_reg),
        .wr_time (time_reg),
        .wr_value(val_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_time (rd_time),
        .rd_value(rd_value)
    );

    // random word goes straight from the input word into the remainder unit
    tkv_mod #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (s_tdata[KB + TB + WB +: RB]),
        .divisor  (fill_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    assign hit = cmp_vld_reg && (rd_key == key_reg);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        time_next    = time_reg;
        val_next     = val_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        sts_next     = sts_reg;
        slot_next    = slot_reg;
        okey_next    = okey_reg;
        otime_next   = otime_reg;
        oval_next    = oval_reg;
        wr_en        = 1'b0;
        wr_addr      = cmp_idx_reg;
        rd_en        = 1'b0;
        rd_addr      = scan_reg[IDX_W-1:0];
        mod_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    key_next     = s_tdata[0 +: KB];
                    time_next    = s_tdata[KB +: TB];
                    val_next     = s_tdata[KB + TB +: VALUE_BITS];
                    scan_next    = '0;
                    cmp_vld_next = 1'b0;
                    slot_next    = '0;
                    okey_next    = '0;
                    otime_next   = '0;
                    oval_next    = '0;
                    unique case (s_tuser) inside
                        tkv_pkg::OP_MERGE, tkv_pkg::OP_LOOKUP: begin
                            state_next = S_SCAN;
                        end
                        tkv_pkg::OP_PICK: begin
                            if (fill_reg == '0) begin
                                sts_next   = tkv_pkg::STS_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_MODW;
                            end
                        end
                        default: begin
                            // unused code: dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // one slot read per cycle, compare the previous slot's data
            S_SCAN: begin
                if (hit) begin
                    state_next = S_OUT;
                    if (op_reg == tkv_pkg::OP_LOOKUP) begin
                        sts_next   = tkv_pkg::STS_FOUND;
                        slot_next  = cmp_idx_reg;
                        okey_next  = rd_key;
                        otime_next = rd_time;
                        oval_next  = rd_value;
                    end else if (time_reg > rd_time) begin
                        wr_en     = 1'b1;
                        wr_addr   = cmp_idx_reg;
                        sts_next  = tkv_pkg::STS_UPDATED;
                        slot_next = cmp_idx_reg;
                    end else begin
                        sts_next = tkv_pkg::STS_STALE;
                    end
                end else if (scan_reg < fill_reg) begin
                    rd_en        = 1'b1;
                    rd_addr      = scan_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end else if (!cmp_vld_reg) begin
                    // key absent
                    state_next = S_OUT;
                    if (op_reg == tkv_pkg::OP_LOOKUP) begin
                        sts_next = tkv_pkg::STS_NOT_FOUND;
                    end else if (fill_reg < DEPTH_F) begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[IDX_W-1:0];
                        sts_next  = tkv_pkg::STS_INSERTED;
                        slot_next = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        sts_next = tkv_pkg::STS_FULL;
                    end
                end else begin
                    cmp_vld_next = 1'b0;
                end
            end

            // wait for the remainder, then read the picked slot
            S_MODW: begin
                if (mod_done) begin
                    rd_en      = 1'b1;
                    rd_addr    = mod_rem[IDX_W-1:0];
                    slot_next  = mod_rem[IDX_W-1:0];
                    state_next = S_PDATA;
                end
            end

            S_PDATA: begin
                sts_next   = tkv_pkg::STS_PICKED;
                okey_next  = rd_key;
                otime_next = rd_time;
                oval_next  = rd_value;
                state_next = S_OUT;
            end

            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // the remainder unit starts as the pick leaves idle
        if (state_reg == S_IDLE && state_next == S_MODW) begin
            mod_start = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        time_reg    <= time_next;
        val_reg     <= val_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        sts_reg     <= sts_next;
        slot_reg    <= slot_next;
        okey_reg    <= okey_next;
        otime_reg   <= otime_next;
        oval_reg    <= oval_next;
    end

    // output word packing
    logic [IDX_W+SB-1:0]      slot_wide;
    logic [FILL_W+UB-1:0]     used_wide;
    logic [VALUE_BITS+WB-1:0] val_wide;

    assign slot_wide = {{SB{1'b0}}, slot_reg};
    assign used_wide = {{UB{1'b0}}, fill_reg};
    assign val_wide  = {{WB{1'b0}}, oval_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = sts_reg;
    assign m_tdata  = {
        {(tkv_pkg::M_TDATA_BITS - SB - KB - TB - WB - UB){1'b0}},
        used_wide[UB-1:0],
        val_wide[WB-1:0],
        otime_reg,
        okey_reg,
        slot_wide[SB-1:0]
    };

    // checks
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("entry count above table depth");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + 1'b1))
        else $error("entry count moved by more than one");

    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && sts_reg == tkv_pkg::STS_PICKED) |-> ({1'b0, slot_reg} < fill_reg))
        else $error("picked slot outside the filled range");

endmodule

// ===== rtl/tkv_store.sv =====
// ----------------------------------------------------------------------------
// tkv_store
// Entry memory: key, timestamp and value per slot, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module tkv_store #(
    parameter int TABLE_DEPTH = tkv_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = tkv_pkg::VALUE_BITS_DEF,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [tkv_pkg::KEY_BITS-1:0]  wr_key,
    input  logic [tkv_pkg::TIME_BITS-1:0] wr_time,
    input  logic [VALUE_BITS-1:0]         wr_value,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [tkv_pkg::KEY_BITS-1:0]  rd_key,
    output logic [tkv_pkg::TIME_BITS-1:0] rd_time,
    output logic [VALUE_BITS-1:0]         rd_value
);

    localparam int ENTRY_W = tkv_pkg::KEY_BITS + tkv_pkg::TIME_BITS + VALUE_BITS;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_value, wr_time, wr_key};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[tkv_pkg::KEY_BITS-1:0];
    assign rd_time  = rd_data_reg[tkv_pkg::KEY_BITS +: tkv_pkg::TIME_BITS];
    assign rd_value = rd_data_reg[ENTRY_W-1 -: VALUE_BITS];

endmodule

// ===== rtl/tkv_mod.sv =====
// ----------------------------------------------------------------------------
// tkv_mod
// Bit-serial restoring remainder unit: random word modulo entry count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tkv_mod #(
    parameter int TABLE_DEPTH = tkv_pkg::TABLE_DEPTH_DEF,
    localparam int FILL_W     = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tkv_pkg::RAND_BITS-1:0] dividend,
    input  logic [FILL_W-1:0]             divisor,
    output logic                          done,
    output logic [FILL_W-1:0]             remainder
);

    localparam int CNT_W = $clog2(tkv_pkg::RAND_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tkv_pkg::RAND_BITS - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [tkv_pkg::RAND_BITS-1:0] dvd_reg;
    logic [FILL_W-1:0]             dsr_reg;
    logic [FILL_W-1:0]             rem_reg;
    logic [FILL_W:0]               trial;
    logic [FILL_W:0]               diff;
    logic [FILL_W-1:0]             rem_step;

    // one shift-and-subtract step
    always_comb begin
        trial = {rem_reg, dvd_reg[tkv_pkg::RAND_BITS-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg}) begin
            rem_step = diff[FILL_W-1:0];
        end else begin
            rem_step = trial[FILL_W-1:0];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[tkv_pkg::RAND_BITS-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== tb/timestamped_key_value_table_checker.sv =====
// ----------------------------------------------------------------------------
// timestamped_key_value_table_checker
// Watches both stream channels of the key/value table, keeps a shadow copy of
// the table, predicts the result word of every accepted operation and
// compares each result word field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module timestamped_key_value_table_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // key_id, timestamp, value_word, random_word
    input  logic [tkv_pkg::S_TDATA_BITS-1:0] s_tdata,
    // operation
    input  logic [tkv_pkg::OP_BITS-1:0]      s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // slot, entry_key, entry_time, entry_value, entries_used, zero fill
    input  logic [tkv_pkg::M_TDATA_BITS-1:0] m_tdata,
    // status
    input  logic [tkv_pkg::STATUS_BITS-1:0]  m_tuser,
    output int                               fail_count,
    output int                               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tkv_pkg::*;

    localparam int DEPTH    = TABLE_DEPTH_DEF;
    localparam int PAD_BITS = M_TDATA_BITS - 137;

    typedef struct packed {
        status_t                status;
        logic [SLOT_BITS-1:0]   slot;
        logic [KEY_BITS-1:0]    key;
        logic [TIME_BITS-1:0]   stamp;
        logic [WORD_BITS-1:0]   value;
        logic [USED_BITS-1:0]   used;
    } reply_t;

    // shadow table
    logic [KEY_BITS-1:0]  table_key   [DEPTH];
    logic [TIME_BITS-1:0] table_time  [DEPTH];
    logic [WORD_BITS-1:0] table_value [DEPTH];
    int unsigned          table_fill;

    reply_t pending_replies [$];

    // apply one operation to the shadow table and return its reply
    function automatic reply_t apply_operation(op_t op, logic [KEY_BITS-1:0] key,
                                               logic [TIME_BITS-1:0] stamp,
                                               logic [WORD_BITS-1:0] value,
                                               logic [RAND_BITS-1:0] rnd);
        reply_t      r;
        int          hit;
        int unsigned s;
        r   = '0;
        hit = -1;
        // lowest matching slot among the valid entries
        for (int i = 0; i < table_fill; i++) begin
            if (hit < 0 && table_key[i] == key) hit = i;
        end
        case (op)
            OP_MERGE: begin
                if (hit < 0) begin
                    if (table_fill < DEPTH) begin
                        table_key[table_fill]   = key;
                        table_time[table_fill]  = stamp;
                        table_value[table_fill] = value;
                        r.status = STS_INSERTED;
                        r.slot   = table_fill[SLOT_BITS-1:0];
                        table_fill++;
                    end else begin
                        r.status = STS_FULL;
                    end
                end else if (stamp > table_time[hit]) begin
                    table_time[hit]  = stamp;
                    table_value[hit] = value;
                    r.status = STS_UPDATED;
                    r.slot   = hit[SLOT_BITS-1:0];
                end else begin
                    r.status = STS_STALE;
                end
            end
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = STS_FOUND;
                    r.slot   = hit[SLOT_BITS-1:0];
                    r.key    = table_key[hit];
                    r.stamp  = table_time[hit];
                    r.value  = table_value[hit];
                end else begin
                    r.status = STS_NOT_FOUND;
                end
            end
            OP_PICK: begin
                if (table_fill == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    s        = rnd % table_fill;
                    r.status = STS_PICKED;
                    r.slot   = s[SLOT_BITS-1:0];
                    r.key    = table_key[s];
                    r.stamp  = table_time[s];
                    r.value  = table_value[s];
                end
            end
            default: ;
        endcase
        r.used = table_fill[USED_BITS-1:0];
        return r;
    endfunction

    // field-by-field compare, returns the number of wrong fields
    function automatic int compare_reply(reply_t want, reply_t got,
                                         logic [PAD_BITS-1:0] pad);
        int errs;
        errs = 0;
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            errs++;
        end
        if (got.key !== want.key) begin
            $error("entry_key: expected %h, got %h", want.key, got.key);
            errs++;
        end
        if (got.stamp !== want.stamp) begin
            $error("entry_time: expected %h, got %h", want.stamp, got.stamp);
            errs++;
        end
        if (got.value !== want.value) begin
            $error("entry_value: expected %h, got %h", want.value, got.value);
            errs++;
        end
        if (got.used !== want.used) begin
            $error("entries_used: expected %0d, got %0d", want.used, got.used);
            errs++;
        end
        if (pad !== '0) begin
            $error("zero fill: expected 0, got %h", pad);
            errs++;
        end
        return errs;
    endfunction

    // predict on accepted operations, check on accepted results
    always @(posedge aclk) begin
        reply_t got;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            table_fill = 0;
            pending_replies.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_MERGE, OP_LOOKUP, OP_PICK:
                        pending_replies.push_back(apply_operation(op_t'(s_tuser),
                            s_tdata[31:0], s_tdata[63:32], s_tdata[127:64],
                            s_tdata[159:128]));
                    default: ; // unused code, dropped without a result
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.slot   = m_tdata[3:0];
                got.key    = m_tdata[35:4];
                got.stamp  = m_tdata[67:36];
                got.value  = m_tdata[131:68];
                got.used   = m_tdata[136:132];
                if (pending_replies.size() == 0) begin
                    $error("result word with no operation outstanding: status %0d",
                           got.status);
                    errs++;
                end else begin
                    errs += compare_reply(pending_replies.pop_front(), got,
                                          m_tdata[M_TDATA_BITS-1:137]);
                end
            end
            fail_count    <= fail_count + errs;
            pending_count <= pending_replies.size();
        end
    end

endmodule

// ===== tb/timestamped_key_value_table_test.sv =====
// ----------------------------------------------------------------------------
// timestamped_key_value_table_test
// Drives the key/value table with a directed opening (empty table, extreme
// keys, times and values, stale and newer merges, misses, picks, the unused
// code) and then random traffic over a small key pool so that the table fills
// and updates, stale merges and full rejections recur, under three settings
// of sender and receiver idling. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module timestamped_key_value_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkv_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 165;
    localparam int DRAIN       = 80;
    localparam int CYCLE_LIMIT = 500000;

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [OP_BITS-1:0]      s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [STATUS_BITS-1:0]  m_tuser;

    int fail_count;
    int pending_count;
    int src_idle_pct  = 14;
    int sink_idle_pct = 78;
    int cycle_count   = 0;

    // key pool and the newest merge time sent per key
    logic [KEY_BITS-1:0]  pool_key  [POOL_SIZE];
    logic [TIME_BITS-1:0] pool_time [POOL_SIZE];

    timestamped_key_value_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    timestamped_key_value_table_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** timestamped_key_value_table: FAILED **");
            $finish;
        end
    end

    // offer one operation word and wait until it is taken
    task automatic send_word(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                             logic [TIME_BITS-1:0] stamp, logic [WORD_BITS-1:0] value,
                             logic [RAND_BITS-1:0] rnd);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, value, stamp, key};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one random operation over the key pool
    task automatic random_word(output logic [OP_BITS-1:0] op);
        int                   ix;
        int                   roll;
        logic [KEY_BITS-1:0]  key;
        logic [TIME_BITS-1:0] stamp;
        logic [RAND_BITS-1:0] rnd;
        ix   = $urandom_range(0, POOL_SIZE - 1);
        key  = ($urandom_range(0, 9) == 0) ? $urandom : pool_key[ix];
        roll = $urandom_range(0, 99);
        op   = (roll < 45) ? OP_MERGE : (roll < 75) ? OP_LOOKUP :
               (roll < 95) ? OP_PICK : OP_UNUSED;
        // mostly newer times, some equal or older, some anything
        roll = $urandom_range(0, 9);
        if (roll < 6)
            stamp = pool_time[ix] + $urandom_range(1, 4);
        else if (roll < 8)
            stamp = pool_time[ix];
        else if (roll < 9)
            stamp = pool_time[ix] - $urandom_range(1, 4);
        else
            stamp = $urandom;
        if (op == OP_MERGE && key == pool_key[ix] && stamp > pool_time[ix])
            pool_time[ix] = stamp;
        rnd = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
        send_word(op, key, stamp, {$urandom, $urandom}, rnd);
    endtask

    // stimulus and verdict
    initial begin
        logic [OP_BITS-1:0] op;
        int                 sent;

        // key pool: extremes, a fixed pattern, then random keys
        pool_key[0]  = 32'h0000_0000;
        pool_time[0] = 32'd1;
        pool_key[1]  = 32'hFFFF_FFFF;
        pool_time[1] = 32'hFFFF_FFFF;
        pool_key[2]  = 32'hA5A5_A5A5;
        pool_time[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++) begin
            pool_key[i]  = $urandom;
            pool_time[i] = (i % 2) ? $urandom : $urandom_range(0, 1000);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening
        send_word(OP_PICK,   32'h0, 32'h0, 64'h0, 32'h0);            // empty table
        send_word(OP_LOOKUP, 32'h0, 32'h0, 64'h0, 32'h0);            // miss on empty
        send_word(OP_MERGE,  32'h0, 32'h0, 64'h0, 32'h0);            // insert slot 0
        send_word(OP_MERGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);  // insert slot 1
        send_word(OP_MERGE,  32'h0, 32'h0, 64'h1234, 32'h0);         // equal time, stale
        send_word(OP_MERGE,  32'h0, 32'h1, 64'h5555_5555_5555_5555, 32'h0); // newer
        send_word(OP_MERGE,  32'hFFFF_FFFF, 32'h0, 64'h0, 32'h0);    // older, stale
        send_word(OP_LOOKUP, 32'h0, 32'h0, 64'h0, 32'h0);
        send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 64'h0, 32'h0);
        send_word(OP_LOOKUP, 32'h1234_5678, 32'h0, 64'h0, 32'h0);    // miss
        send_word(OP_UNUSED, '1, '1, '1, '1);                        // dropped
        send_word(OP_PICK,   32'h0, 32'h0, 64'h0, 32'h0);
        send_word(OP_PICK,   32'h0, 32'h0, 64'h0, 32'hFFFF_FFFF);
        send_word(OP_MERGE,  32'hA5A5_A5A5, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                  32'h0);
        send_word(OP_PICK,   32'h0, 32'h0, 64'h0, 32'h7FFF_FFFF);
        send_word(OP_MERGE,  32'hA5A5_A5A5, 32'h8000_0001, 64'h0, 32'h0);

        // random traffic in three idling settings
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 78 : 0;
            sink_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 14 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_word(op);
                if (op != OP_UNUSED) sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0)
            $display("** timestamped_key_value_table: PASSED **");
        else
            $display("** timestamped_key_value_table: FAILED **");
        $finish;
    end

endmodule
